### design/bsc_pkg.sv
package bsc_pkg;

	// configuration port shape
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_VALUE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH_VALUE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE   = 3'd6;

	// register reset values
	localparam logic signed [15:0] RST_STEP_SIZE    = 16'sd1;
	localparam logic signed [15:0] RST_START_VALUE  = 16'sd0;
	localparam logic signed [15:0] RST_FINISH_VALUE = 16'sd15;
	localparam logic               RST_WRAP_ENABLE  = 1'b0;
	localparam logic signed [15:0] RST_GAIN         = 16'sd256;
	localparam logic signed [23:0] RST_BIAS         = 24'sd0;
	localparam logic               RST_FRAME_MODE   = 1'b0;

	typedef struct packed {
		logic signed [15:0] step_size;
		logic signed [15:0] start_value;
		logic signed [15:0] finish_value;
		logic               wrap_enable;
		logic signed [15:0] gain;
		logic signed [23:0] bias;
		logic               frame_mode;
	} cfg_t;

	// beat handed from the count stage to the scaling stage
	typedef struct packed {
		logic               valid;
		logic               use_bias;
		logic signed [15:0] count;
	} beat_t;

endpackage

### design/bsc_cfg.sv
module bsc_cfg
	import bsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register file, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size    <= RST_STEP_SIZE;
			cfg_q.start_value  <= RST_START_VALUE;
			cfg_q.finish_value <= RST_FINISH_VALUE;
			cfg_q.wrap_enable  <= RST_WRAP_ENABLE;
			cfg_q.gain         <= RST_GAIN;
			cfg_q.bias         <= RST_BIAS;
			cfg_q.frame_mode   <= RST_FRAME_MODE;
		end else if (wr_en) begin
			case (wr_index)
				REG_STEP_SIZE:    cfg_q.step_size    <= wr_data[15:0];
				REG_START_VALUE:  cfg_q.start_value  <= wr_data[15:0];
				REG_FINISH_VALUE: cfg_q.finish_value <= wr_data[15:0];
				REG_WRAP_ENABLE:  cfg_q.wrap_enable  <= wr_data[0];
				REG_GAIN:         cfg_q.gain         <= wr_data[15:0];
				REG_BIAS:         cfg_q.bias         <= wr_data[23:0];
				REG_FRAME_MODE:   cfg_q.frame_mode   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/bsc_count.sv
module bsc_count
	import bsc_pkg::*;
#(
	parameter int unsigned FRAME_LENGTH = 128
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] count_sample,
	input  logic signed [15:0] reset_sample,
	input  logic               s2_ready,
	output beat_t              beat_s1
);

	localparam int unsigned POS_W = $clog2(FRAME_LENGTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);

	logic signed [15:0] current_count_q;
	logic [POS_W-1:0]   frame_position_q;
	logic               frame_count_seen_q;
	logic               frame_reset_seen_q;
	logic signed [15:0] frame_held_count_q;

	logic signed [15:0] current_count_n;
	logic [POS_W-1:0]   frame_position_n;
	logic               frame_count_seen_n;
	logic               frame_reset_seen_n;
	logic signed [15:0] frame_held_count_n;
	logic signed [15:0] count_out;

	logic               valid_s1;
	logic               use_bias_s1;
	logic signed [15:0] count_s1;

	logic cnt_evt;
	logic rst_evt;
	logic last;
	logic take;

	// one count update: step, bound check, then reset event
	function automatic logic signed [15:0] advance(
		input logic signed [15:0] v,
		input logic               cnt,
		input logic               rst,
		input cfg_t               c
	);
		logic signed [16:0] sum;
		logic signed [16:0] hi;
		logic signed [16:0] lo;
		logic signed [15:0] r;
		sum = $signed({v[15], v}) + $signed({c.step_size[15], c.step_size});
		hi  = $signed({c.finish_value[15], c.finish_value});
		lo  = $signed({c.start_value[15], c.start_value});
		r   = v;
		if (cnt) begin
			if (sum > hi)
				r = c.wrap_enable ? c.start_value : c.finish_value;
			else if (sum < lo)
				r = c.wrap_enable ? c.finish_value : c.start_value;
			else
				r = sum[15:0];
		end
		if (rst)
			r = (c.step_size > 16'sd0) ? c.start_value : c.finish_value;
		return r;
	endfunction

	// handshake: s1 moves on when empty or when the next stage takes it
	assign in_stall = valid_s1 && !s2_ready;
	assign take     = in_valid && !in_stall;

	assign cnt_evt = count_sample > 16'sd0;
	assign rst_evt = reset_sample > 16'sd0;
	assign last    = frame_position_q == POS_LAST;

	// next state for the accepted beat
	always_comb begin
		current_count_n    = current_count_q;
		frame_held_count_n = frame_held_count_q;
		frame_count_seen_n = 1'b0;
		frame_reset_seen_n = 1'b0;
		count_out          = current_count_q;
		if (cfg.frame_mode) begin
			frame_held_count_n = (frame_position_q == '0) ? current_count_q
				: frame_held_count_q;
			count_out          = frame_held_count_n;
			frame_count_seen_n = frame_count_seen_q || cnt_evt;
			frame_reset_seen_n = frame_reset_seen_q || rst_evt;
			if (last) begin
				current_count_n    = advance(current_count_q, frame_count_seen_n,
					frame_reset_seen_n, cfg);
				frame_count_seen_n = 1'b0;
				frame_reset_seen_n = 1'b0;
			end
		end else begin
			current_count_n    = advance(current_count_q, cnt_evt, rst_evt, cfg);
			frame_held_count_n = current_count_n;
			count_out          = current_count_n;
		end
		frame_position_n = last ? '0 : frame_position_q + POS_W'(1);
	end

	// counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_count_q    <= '0;
			frame_position_q   <= '0;
			frame_count_seen_q <= 1'b0;
			frame_reset_seen_q <= 1'b0;
			frame_held_count_q <= '0;
		end else if (take) begin
			current_count_q    <= current_count_n;
			frame_position_q   <= frame_position_n;
			frame_count_seen_q <= frame_count_seen_n;
			frame_reset_seen_q <= frame_reset_seen_n;
			frame_held_count_q <= frame_held_count_n;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			count_s1    <= count_out;
			use_bias_s1 <= cfg.frame_mode;
		end
	end

	assign beat_s1.valid    = valid_s1;
	assign beat_s1.use_bias = use_bias_s1;
	assign beat_s1.count    = count_s1;

endmodule

### design/bsc_scale.sv
module bsc_scale
	import bsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  beat_t              beat_s1,
	output logic               s2_ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] level,
	output logic signed [15:0] count_value
);

	logic               out_valid_q;
	logic signed [31:0] level_q;
	logic signed [15:0] count_value_q;

	logic signed [31:0] product;
	logic signed [23:0] offset;
	logic signed [32:0] total;
	logic signed [31:0] level_sat;

	assign s2_ready = !out_valid_q || !out_stall;

	// count times gain, plus bias in frame mode, saturated to 32 bits
	assign product = 32'(beat_s1.count) * 32'(cfg.gain);
	assign offset  = beat_s1.use_bias ? cfg.bias : 24'sd0;
	assign total   = $signed({product[31], product}) + 33'(offset);

	always_comb begin
		if (total[32] != total[31])
			level_sat = total[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			level_sat = total[31:0];
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_ready) begin
			out_valid_q <= beat_s1.valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (s2_ready && beat_s1.valid) begin
			level_q       <= level_sat;
			count_value_q <= beat_s1.count;
		end
	end

	assign out_valid   = out_valid_q;
	assign level       = level_q;
	assign count_value = count_value_q;

endmodule

### design/bounded_step_counter_core.sv
// bounded step counter: up/down count with wrap or clamp, scaled output
// path: an accepted beat passes the stage 1 and output registers
// throughput: one beat per cycle unless out_stall holds the output;
// the count update closes in stage 1, the gain multiply in the next stage
// reset: arst_n clears the count and frame state and loads register defaults
module bounded_step_counter_core
	import bsc_pkg::*;
#(
	parameter int unsigned FRAME_LENGTH = 128
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    count_sample,
	input  logic signed [15:0]    reset_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    level,
	output logic signed [15:0]    count_value
);

	cfg_t  cfg;
	beat_t beat_s1;
	logic  s2_ready;

	// configuration registers
	bsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// count update and frame tracking
	bsc_count #(
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.count_sample (count_sample),
		.reset_sample (reset_sample),
		.s2_ready     (s2_ready),
		.beat_s1      (beat_s1)
	);

	// gain, bias and output register
	bsc_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.beat_s1     (beat_s1),
		.s2_ready    (s2_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.level       (level),
		.count_value (count_value)
	);

endmodule

### bench/bounded_step_counter_core_tb.sv
`timescale 1ns / 1ps

module bounded_step_counter_core_tb
	import bsc_pkg::*;
;

	// frame length of the default build
	localparam int unsigned FRAME_LEN = 128;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam longint LEVEL_MAX = 64'sd2147483647;
	localparam longint LEVEL_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [15:0] cnt;
		logic signed [15:0] rst;
	} sample_pair_t;

	typedef struct packed {
		logic signed [31:0] level;
		logic signed [15:0] count;
	} level_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] count_sample = '0;
	logic signed [15:0] reset_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] level;
	logic signed [15:0] count_value;

	// stimulus and expectation stores
	sample_pair_t pending_pairs[$];
	level_beat_t expected_levels[$];
	int sent_total = 0;
	int taken_total = 0;
	int levels_checked = 0;
	int mismatch_count = 0;
	int reg_writes = 0;
	int frame_updates = 0;
	int bound_hits = 0;
	int cycle_count = 0;
	int send_idle_pct = 35;
	int drain_idle_pct = 35;
	bit hold_phase = 1'b0;
	int hold_left = 0;
	bit hold_taken = 1'b0;

	// predictor copy of the registers
	logic signed [15:0] step_sz = RST_STEP_SIZE;
	logic signed [15:0] lo_bound = RST_START_VALUE;
	logic signed [15:0] hi_bound = RST_FINISH_VALUE;
	logic wrap_on = RST_WRAP_ENABLE;
	logic signed [15:0] gain_q88 = RST_GAIN;
	logic signed [23:0] bias_q8 = RST_BIAS;
	logic frame_on = RST_FRAME_MODE;

	// predictor copy of the counter state
	logic signed [15:0] cur_count = '0;
	logic signed [15:0] held_count = '0;
	int unsigned frame_pos = 0;
	bit frame_cnt_seen = 1'b0;
	bit frame_rst_seen = 1'b0;

	bounded_step_counter_core #(
		.FRAME_LENGTH(FRAME_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.count_sample(count_sample),
		.reset_sample(reset_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.count_value(count_value)
	);

	always #2 clk = ~clk;

	// one count/reset update with wrap or clamp at the crossed bound
	function automatic logic signed [15:0] step_bounded(input logic signed [15:0] v,
			input bit is_count, input bit is_reset);
		logic signed [16:0] sum;
		logic signed [15:0] r;
		r = v;
		if (is_count) begin
			sum = 17'(v) + 17'(step_sz);
			if (sum > hi_bound) begin
				r = wrap_on ? lo_bound : hi_bound;
				bound_hits++;
			end else if (sum < lo_bound) begin
				r = wrap_on ? hi_bound : lo_bound;
				bound_hits++;
			end else begin
				r = sum[15:0];
			end
		end
		if (is_reset)
			r = (step_sz > 0) ? lo_bound : hi_bound;
		return r;
	endfunction

	// count times gain plus offset, saturated to 32 bits
	function automatic logic signed [31:0] scale_level(input logic signed [15:0] v,
			input logic signed [23:0] off);
		longint prod;
		prod = longint'(v) * longint'(gain_q88) + longint'(off);
		if (prod > LEVEL_MAX)
			prod = LEVEL_MAX;
		if (prod < LEVEL_MIN)
			prod = LEVEL_MIN;
		return prod[31:0];
	endfunction

	// expected output beat for one accepted sample pair
	function automatic void predict_pair(input logic signed [15:0] cs,
			input logic signed [15:0] rs);
		bit is_count;
		bit is_reset;
		bit last;
		level_beat_t b;
		is_count = cs > 0;
		is_reset = rs > 0;
		last = (frame_pos == FRAME_LEN - 1);
		if (frame_on) begin
			if (frame_pos == 0)
				held_count = cur_count;
			b.level = scale_level(held_count, bias_q8);
			b.count = held_count;
			frame_cnt_seen = frame_cnt_seen | is_count;
			frame_rst_seen = frame_rst_seen | is_reset;
			if (last) begin
				cur_count = step_bounded(cur_count, frame_cnt_seen, frame_rst_seen);
				frame_cnt_seen = 1'b0;
				frame_rst_seen = 1'b0;
				frame_updates++;
			end
		end else begin
			cur_count = step_bounded(cur_count, is_count, is_reset);
			held_count = cur_count;
			frame_cnt_seen = 1'b0;
			frame_rst_seen = 1'b0;
			b.level = scale_level(cur_count, 24'sd0);
			b.count = cur_count;
		end
		frame_pos = last ? 0 : frame_pos + 1;
		expected_levels.push_back(b);
	endfunction

	function automatic void report_miss(input string what, input longint want_v,
			input longint got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at beat %0d: %s expected %0d got %0d",
				levels_checked, what, want_v, got_v);
	endfunction

	// random sample, pct_event percent of them above zero
	function automatic logic signed [15:0] pick_sample(input int unsigned pct_event);
		logic signed [15:0] s;
		s = 16'($urandom);
		if ($urandom_range(99) < pct_event) begin
			s[15] = 1'b0;
			case ($urandom_range(3))
				0: s = 16'sd1;
				1: s = 16'sh7fff;
				default: if (s == 16'sd0) s = 16'sd1;
			endcase
		end else begin
			s[15] = 1'b1;
			case ($urandom_range(3))
				0: s = 16'sd0;
				1: s = 16'sh8000;
				2: s = -16'sd1;
				default: ;
			endcase
		end
		return s;
	endfunction

	task automatic queue_pair(input int cs, input int rs);
		sample_pair_t p;
		p.cnt = cs[15:0];
		p.rst = rs[15:0];
		pending_pairs.push_back(p);
		sent_total++;
	endtask

	// register write, mirrored into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		reg_writes++;
		case (idx)
			REG_STEP_SIZE: step_sz = value[15:0];
			REG_START_VALUE: lo_bound = value[15:0];
			REG_FINISH_VALUE: hi_bound = value[15:0];
			REG_WRAP_ENABLE: wrap_on = value[0];
			REG_GAIN: gain_q88 = value[15:0];
			REG_BIAS: bias_q8 = value[23:0];
			REG_FRAME_MODE: frame_on = value[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() != 0 || taken_total != sent_total
				|| expected_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int unsigned pct_count,
			input int unsigned pct_reset);
		for (int i = 0; i < n; i++)
			queue_pair(pick_sample(pct_count), pick_sample(pct_reset));
		wait_drained();
	endtask

	// input side: offer queued beats, idling at random
	always @(posedge clk) begin : drive_samples
		sample_pair_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_pair(count_sample, reset_sample);
				taken_total++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_pairs.pop_front();
					in_valid <= 1'b1;
					count_sample <= nxt.cnt;
					reset_sample <= nxt.rst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side stall: random, plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_phase && !hold_taken) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < drain_idle_pct);
		end
	end

	// output beats against the oldest expectation
	always @(posedge clk) begin : check_levels
		level_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_levels.size() == 0) begin
				report_miss("beat with nothing pending, level", 0, level);
			end else begin
				want = expected_levels.pop_front();
				if (level !== want.level)
					report_miss("level", want.level, level);
				if (count_value !== want.count)
					report_miss("count_value", want.count, count_value);
			end
			levels_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d levels still pending",
				cycle_count, expected_levels.size());
			$display("bounded_step_counter_core verification failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: register defaults, sample extremes, clamp at finish
		queue_pair(32767, -32768);
		queue_pair(1, 0);
		queue_pair(0, 0);
		queue_pair(-1, -1);
		queue_pair(-32768, -32768);
		queue_pair(0, 1);
		queue_pair(0, 32767);
		queue_pair(32767, 32767);
		for (int i = 0; i < 17; i++)
			queue_pair(1, -32768);
		wait_drained();

		// sample mode, clamp, defaults
		run_random(70, 55, 10);

		// wrap with a negative gain
		write_reg(REG_WRAP_ENABLE, 1);
		write_reg(REG_STEP_SIZE, 3);
		write_reg(REG_START_VALUE, -5);
		write_reg(REG_FINISH_VALUE, 20);
		write_reg(REG_GAIN, -256);
		run_random(70, 55, 8);

		// most negative step over the full range, clamp
		write_reg(REG_WRAP_ENABLE, 0);
		write_reg(REG_STEP_SIZE, -32768);
		write_reg(REG_START_VALUE, -32768);
		write_reg(REG_FINISH_VALUE, 32767);
		write_reg(REG_GAIN, 32767);
		run_random(60, 60, 5);

		// most positive step over the full range, wrap
		write_reg(REG_WRAP_ENABLE, 1);
		write_reg(REG_STEP_SIZE, 32767);
		write_reg(REG_GAIN, -32768);
		run_random(60, 60, 5);

		// start above finish, both step signs
		write_reg(REG_START_VALUE, 10);
		write_reg(REG_FINISH_VALUE, -10);
		write_reg(REG_STEP_SIZE, -4);
		run_random(30, 60, 10);
		write_reg(REG_WRAP_ENABLE, 0);
		write_reg(REG_STEP_SIZE, 6);
		run_random(30, 60, 10);

		// frame mode entered mid-frame, largest bias
		write_reg(REG_START_VALUE, 0);
		write_reg(REG_FINISH_VALUE, 100);
		write_reg(REG_STEP_SIZE, 7);
		write_reg(REG_WRAP_ENABLE, 1);
		write_reg(REG_GAIN, 32767);
		write_reg(REG_BIAS, 8388607);
		write_reg(REG_FRAME_MODE, 1);
		run_random(130, 15, 4);

		// frame mode, registers changed mid-frame, smallest bias
		write_reg(REG_BIAS, -8388608);
		write_reg(REG_GAIN, -32768);
		write_reg(REG_STEP_SIZE, -5);
		write_reg(REG_WRAP_ENABLE, 0);
		run_random(90, 10, 3);
		write_reg(REG_STEP_SIZE, 0);
		write_reg(REG_GAIN, 128);
		run_random(90, 10, 3);

		// back to sample mode, bias must not apply; long output hold-off
		write_reg(REG_FRAME_MODE, 0);
		write_reg(REG_STEP_SIZE, 2);
		write_reg(REG_BIAS, 1000);
		hold_phase = 1'b1;
		run_random(60, 55, 8);
		hold_phase = 1'b0;

		// unused register index is ignored; stretch with no idling
		write_reg(REG_NONE, 24'hffffff);
		send_idle_pct = 0;
		drain_idle_pct = 0;
		run_random(80, 50, 6);
		send_idle_pct = 35;
		drain_idle_pct = 35;

		// random settings
		for (int k = 0; k < 3; k++) begin
			write_reg(REG_STEP_SIZE, int'($urandom_range(65535)) - 32768);
			write_reg(REG_START_VALUE, int'($urandom_range(65535)) - 32768);
			write_reg(REG_FINISH_VALUE, int'($urandom_range(65535)) - 32768);
			write_reg(REG_WRAP_ENABLE, $urandom_range(1));
			write_reg(REG_GAIN, int'($urandom_range(65535)) - 32768);
			write_reg(REG_BIAS, int'($urandom_range(24'hffffff)) - 8388608);
			write_reg(REG_FRAME_MODE, $urandom_range(1));
			run_random(25, 50, 8);
		end

		repeat (10) @(posedge clk);
		if (expected_levels.size() != 0)
			$display("%0d expected levels never arrived", expected_levels.size());
		$display("covered %0d sample pairs and %0d output beats after %0d register writes,",
			taken_total, levels_checked, reg_writes);
		$display("with %0d bound crossings and %0d frame-end updates; %0d mismatches",
			bound_hits, frame_updates, mismatch_count);
		if (mismatch_count == 0 && expected_levels.size() == 0)
			$display("bounded_step_counter_core verification clean");
		else
			$display("bounded_step_counter_core verification failed");
		$finish;
	end

endmodule
